>>> design/sma_pkg.sv
// shared constants, types and arithmetic helpers of the small matrix engine
package sma_pkg;

   localparam int MAX_DIM    = 8;
   localparam int DATA_WIDTH = 32;

   localparam int VALUE_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int ELEM_W    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int SUM_W     = VALUE_W + 1;
   localparam int ACC_W     = PROD_W - FRAC_BITS + $clog2(MAX_DIM) + 1;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_DIM_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_A_COLS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_B_ROWS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALAR = 3'd5;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_SUB   = 2'd1;
   localparam logic [1:0] MODE_MUL   = 2'd2;
   localparam logic [1:0] MODE_SCALE = 2'd3;

   localparam logic [1:0] OP_LOAD_A = 2'd0;
   localparam logic [1:0] OP_LOAD_B = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;

   localparam logic [VALUE_W-1:0] SCALAR_RESET = 32'h0001_0000;

   localparam longint SAT_HI = (longint'(1) <<< (ELEM_W - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;
   localparam logic signed [ACC_W-1:0] ACC_SAT_HI = ACC_W'(SAT_HI);
   localparam logic signed [ACC_W-1:0] ACC_SAT_LO = ACC_W'(SAT_LO);

   typedef struct packed {
      logic [1:0]                mode;
      logic [DIM_W-1:0]          a_cols;
      logic [DIM_W-1:0]          a_rows;
      logic [DIM_W-1:0]          b_cols;
      logic [DIM_W-1:0]          b_rows;
      logic signed [VALUE_W-1:0] scalar;
   } cfg_type;

   typedef struct packed {
      logic                      valid;
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      size_error;
   } rsp_type;

   function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
   endfunction

   // clamp a wide value into the element range
   function automatic logic signed [VALUE_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] c;
      c = v;
      if (v > ACC_SAT_HI) c = ACC_SAT_HI;
      else if (v < ACC_SAT_LO) c = ACC_SAT_LO;
      return VALUE_W'(c);
   endfunction

endpackage

>>> design/small_matrix_arithmetic_core.sv
// top level of the small matrix engine: registers, stores and run sequencer
// loads are accepted back to back; busy stays low for them
// a run holds busy while it issues and until its last term has left stage 1 and stage 2
// results come one per element, registered through the issue state, stage 1, stage 2 and the
// result register; a size error result follows the acceptance cycle
// no receiver stall; synchronous reset restores the registers and clears both stores
module small_matrix_arithmetic_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // input transactions
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_op,
   input  logic [sma_pkg::IDX_W-1:0]             req_col,
   input  logic [sma_pkg::IDX_W-1:0]             req_row,
   input  logic signed [sma_pkg::VALUE_W-1:0]    req_value,
   // result transactions
   output logic                                  rsp_strobe,
   output logic [sma_pkg::IDX_W-1:0]             rsp_out_col,
   output logic [sma_pkg::IDX_W-1:0]             rsp_out_row,
   output logic signed [sma_pkg::VALUE_W-1:0]    rsp_out_value,
   output logic                                  rsp_last,
   output logic                                  rsp_size_error,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sma_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sma_pkg::CSR_DATA_W-1:0]        csr_data
);

   sma_pkg::cfg_type                   cfg_ff, cfg_in;
   logic                               csr_write;
   logic [sma_pkg::CSR_DIM_W-1:0]      dim_raw;
   logic [sma_pkg::DIM_W-1:0]          dim_val;
   logic                               dim_ok;
   logic                               clear_a, clear_b;
   logic                               load_ok, a_wr_en, b_wr_en;
   logic [sma_pkg::ADDR_W-1:0]         wr_addr, a_rd_addr, b_rd_addr;
   logic signed [sma_pkg::VALUE_W-1:0] wr_data, a_rd_data, b_rd_data;
   sma_pkg::rsp_type                   rsp;

   // register writes wait while a transaction is offered or in flight
   assign csr_ready = !busy && !start;
   assign csr_write = csr_valid && csr_ready;

   // size write: zero is dropped, anything above the store size clamps to it
   always_comb begin
      dim_raw = csr_data[sma_pkg::CSR_DIM_W-1:0];
      dim_ok  = (dim_raw != '0);
      if (dim_raw > sma_pkg::CSR_DIM_W'(sma_pkg::MAX_DIM)) begin
         dim_val = sma_pkg::DIM_W'(sma_pkg::MAX_DIM);
      end else begin
         dim_val = sma_pkg::DIM_W'(dim_raw);
      end

      cfg_in  = cfg_ff;
      clear_a = 1'b0;
      clear_b = 1'b0;
      if (csr_write) begin
         case (csr_index)
            sma_pkg::CSR_MODE: cfg_in.mode = csr_data[1:0];
            sma_pkg::CSR_A_COLS: begin
               if (dim_ok) begin
                  cfg_in.a_cols = dim_val;
                  clear_a       = 1'b1;
               end
            end
            sma_pkg::CSR_A_ROWS: begin
               if (dim_ok) begin
                  cfg_in.a_rows = dim_val;
                  clear_a       = 1'b1;
               end
            end
            sma_pkg::CSR_B_COLS: begin
               if (dim_ok) begin
                  cfg_in.b_cols = dim_val;
                  clear_b       = 1'b1;
               end
            end
            sma_pkg::CSR_B_ROWS: begin
               if (dim_ok) begin
                  cfg_in.b_rows = dim_val;
                  clear_b       = 1'b1;
               end
            end
            sma_pkg::CSR_SCALAR: cfg_in.scalar = signed'(csr_data[sma_pkg::VALUE_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= sma_pkg::MODE_ADD;
         cfg_ff.a_cols <= sma_pkg::DIM_W'(1);
         cfg_ff.a_rows <= sma_pkg::DIM_W'(1);
         cfg_ff.b_cols <= sma_pkg::DIM_W'(1);
         cfg_ff.b_rows <= sma_pkg::DIM_W'(1);
         cfg_ff.scalar <= sma_pkg::SCALAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // load transactions write straight into a store, dropped outside the size
   // (read data is only used while busy, so a load never meets a read of the same entry)
   always_comb begin
      load_ok = start && !busy;
      a_wr_en = load_ok && (req_op == sma_pkg::OP_LOAD_A) &&
                (sma_pkg::DIM_W'(req_col) < cfg_ff.a_cols) &&
                (sma_pkg::DIM_W'(req_row) < cfg_ff.a_rows);
      b_wr_en = load_ok && (req_op == sma_pkg::OP_LOAD_B) &&
                (sma_pkg::DIM_W'(req_col) < cfg_ff.b_cols) &&
                (sma_pkg::DIM_W'(req_row) < cfg_ff.b_rows);
      wr_addr = sma_pkg::addr_of(req_row, req_col);
      wr_data = sma_pkg::sat_acc(sma_pkg::ACC_W'(req_value));
   end

   sma_store u_a_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_a),
      .wr_en   (a_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   sma_store u_b_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_b),
      .wr_en   (b_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // run transactions: issue, multiply/add, accumulate/saturate, result register
   sma_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .op        (req_op),
      .cfg       (cfg_ff),
      .a_rd_data (a_rd_data),
      .b_rd_data (b_rd_data),
      .busy      (busy),
      .a_rd_addr (a_rd_addr),
      .b_rd_addr (b_rd_addr),
      .rsp       (rsp)
   );

   assign rsp_strobe     = rsp.valid;
   assign rsp_out_col    = rsp.col;
   assign rsp_out_row    = rsp.row;
   assign rsp_out_value  = rsp.value;
   assign rsp_last       = rsp.last;
   assign rsp_size_error = rsp.size_error;

endmodule

>>> design/sma_store.sv
// element store: one write port, one registered read port, valid bit per entry
module sma_store (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear,
   input  logic                               wr_en,
   input  logic [sma_pkg::ADDR_W-1:0]         wr_addr,
   input  logic signed [sma_pkg::VALUE_W-1:0] wr_data,
   input  logic [sma_pkg::ADDR_W-1:0]         rd_addr,
   output logic signed [sma_pkg::VALUE_W-1:0] rd_data
);

   logic signed [sma_pkg::VALUE_W-1:0] mem [sma_pkg::DEPTH];
   logic [sma_pkg::DEPTH-1:0]          valid_ff;
   logic signed [sma_pkg::VALUE_W-1:0] rd_data_ff;
   logic                               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // entries never written since reset or a clear read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> design/sma_engine.sv
// run sequencer: walks the stores, multiplies, accumulates and emits results
module sma_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [1:0]                         op,
   input  sma_pkg::cfg_type                   cfg,
   input  logic signed [sma_pkg::VALUE_W-1:0] a_rd_data,
   input  logic signed [sma_pkg::VALUE_W-1:0] b_rd_data,
   output logic                               busy,
   output logic [sma_pkg::ADDR_W-1:0]         a_rd_addr,
   output logic [sma_pkg::ADDR_W-1:0]         b_rd_addr,
   output sma_pkg::rsp_type                   rsp
);

   typedef enum logic {ST_IDLE, ST_ISSUE} state_type;

   typedef struct packed {
      logic                          first;
      logic                          last_elem;
      logic                          last_run;
      logic [sma_pkg::IDX_W-1:0]     row;
      logic [sma_pkg::IDX_W-1:0]     col;
   } tag_type;

   state_type                        state_ff, state_in;
   logic [1:0]                       mode_ff, mode_in;
   logic [sma_pkg::DIM_W-1:0]        rows_ff, rows_in;
   logic [sma_pkg::DIM_W-1:0]        cols_ff, cols_in;
   logic [sma_pkg::DIM_W-1:0]        inner_ff, inner_in;
   logic signed [sma_pkg::VALUE_W-1:0] scalar_ff, scalar_in;
   logic [sma_pkg::IDX_W-1:0]        r_ff, r_in, c_ff, c_in, i_ff, i_in;
   logic                             s1_valid_ff, s1_valid_in;
   tag_type                          s1_tag_ff, s1_tag_in;
   logic                             s2_valid_ff, s2_valid_in;
   tag_type                          s2_tag_ff, s2_tag_in;
   logic signed [sma_pkg::ACC_W-1:0] s2_term_ff, s2_term_in;
   logic signed [sma_pkg::ACC_W-1:0] acc_ff, acc_in;
   sma_pkg::rsp_type                 rsp_ff, rsp_in;

   logic                             run_go, mismatch, last_i, last_c, last_r;
   logic [sma_pkg::IDX_W-1:0]        a_col, b_row;
   logic signed [sma_pkg::VALUE_W-1:0] b_op;
   logic signed [sma_pkg::PROD_W-1:0]  prod;
   logic signed [sma_pkg::SUM_W-1:0]   sum;
   logic signed [sma_pkg::ACC_W-1:0]   acc_sum;

   assign busy = (state_ff != ST_IDLE) || s1_valid_ff || s2_valid_ff;
   assign rsp  = rsp_ff;

   always_comb begin
      run_go   = start && !busy && (op == sma_pkg::OP_RUN);
      mismatch = 1'b0;
      if (cfg.mode inside {sma_pkg::MODE_ADD, sma_pkg::MODE_SUB}) begin
         mismatch = (cfg.a_cols != cfg.b_cols) || (cfg.a_rows != cfg.b_rows);
      end else if (cfg.mode == sma_pkg::MODE_MUL) begin
         mismatch = (cfg.a_cols != cfg.b_rows);
      end

      // issue: address generation and loop counters
      last_i = (mode_ff != sma_pkg::MODE_MUL) ||
               (sma_pkg::DIM_W'(i_ff) + 1'b1 == inner_ff);
      last_c = (sma_pkg::DIM_W'(c_ff) + 1'b1 == cols_ff);
      last_r = (sma_pkg::DIM_W'(r_ff) + 1'b1 == rows_ff);
      a_col  = (mode_ff == sma_pkg::MODE_MUL) ? i_ff : c_ff;
      b_row  = (mode_ff == sma_pkg::MODE_MUL) ? i_ff : r_ff;
      a_rd_addr = sma_pkg::addr_of(r_ff, a_col);
      b_rd_addr = sma_pkg::addr_of(b_row, c_ff);

      state_in  = state_ff;
      mode_in   = mode_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      inner_in  = inner_ff;
      scalar_in = scalar_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      i_in      = i_ff;

      s1_valid_in         = (state_ff == ST_ISSUE);
      s1_tag_in.first     = (i_ff == '0);
      s1_tag_in.last_elem = last_i;
      s1_tag_in.last_run  = last_i && last_c && last_r;
      s1_tag_in.row       = r_ff;
      s1_tag_in.col       = c_ff;

      case (state_ff)
         ST_IDLE: begin
            if (run_go && !mismatch) begin
               state_in  = ST_ISSUE;
               mode_in   = cfg.mode;
               rows_in   = cfg.a_rows;
               cols_in   = (cfg.mode == sma_pkg::MODE_MUL) ? cfg.b_cols : cfg.a_cols;
               inner_in  = cfg.a_cols;
               scalar_in = cfg.scalar;
               r_in      = '0;
               c_in      = '0;
               i_in      = '0;
            end
         end
         ST_ISSUE: begin
            if (last_i) begin
               i_in = '0;
               if (last_c) begin
                  c_in = '0;
                  if (last_r) begin
                     state_in = ST_IDLE;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end else begin
                  c_in = c_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // stage 1: store data arrives, one multiply or add
      b_op = (mode_ff == sma_pkg::MODE_SCALE) ? scalar_ff : b_rd_data;
      prod = sma_pkg::PROD_W'(a_rd_data) * sma_pkg::PROD_W'(b_op);
      if (mode_ff == sma_pkg::MODE_SUB) begin
         sum = sma_pkg::SUM_W'(a_rd_data) - sma_pkg::SUM_W'(b_rd_data);
      end else begin
         sum = sma_pkg::SUM_W'(a_rd_data) + sma_pkg::SUM_W'(b_rd_data);
      end
      // arithmetic shift of the product is the floor truncation
      if (mode_ff inside {sma_pkg::MODE_MUL, sma_pkg::MODE_SCALE}) begin
         s2_term_in = sma_pkg::ACC_W'(signed'(prod[sma_pkg::PROD_W-1:sma_pkg::FRAC_BITS]));
      end else begin
         s2_term_in = sma_pkg::ACC_W'(sum);
      end
      s2_valid_in = s1_valid_ff;
      s2_tag_in   = s1_tag_ff;

      // stage 2: accumulate, saturate on the last term of an element
      acc_sum = s2_tag_ff.first ? s2_term_ff : acc_ff + s2_term_ff;
      acc_in  = s2_valid_ff ? acc_sum : acc_ff;

      rsp_in            = rsp_ff;
      rsp_in.valid      = 1'b0;
      if (s2_valid_ff && s2_tag_ff.last_elem) begin
         rsp_in.valid      = 1'b1;
         rsp_in.col        = s2_tag_ff.col;
         rsp_in.row        = s2_tag_ff.row;
         rsp_in.value      = sma_pkg::sat_acc(acc_sum);
         rsp_in.last       = s2_tag_ff.last_run;
         rsp_in.size_error = 1'b0;
      end else if (run_go && mismatch) begin
         rsp_in.valid      = 1'b1;
         rsp_in.col        = '0;
         rsp_in.row        = '0;
         rsp_in.value      = '0;
         rsp_in.last       = 1'b1;
         rsp_in.size_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         rsp_ff      <= rsp_in;
      end
      mode_ff    <= mode_in;
      rows_ff    <= rows_in;
      cols_ff    <= cols_in;
      inner_ff   <= inner_in;
      scalar_ff  <= scalar_in;
      r_ff       <= r_in;
      c_ff       <= c_in;
      i_ff       <= i_in;
      s1_tag_ff  <= s1_tag_in;
      s2_tag_ff  <= s2_tag_in;
      s2_term_ff <= s2_term_in;
      acc_ff     <= acc_in;
   end

endmodule

>>> tb/matrix_tracker_pkg.sv
`timescale 1ns / 1ps
// result tracker of the matrix engine testbench: register copy, store copies, expected elements
package matrix_tracker_pkg;

   import sma_pkg::*;

   typedef struct {
      logic [IDX_W-1:0]          col;
      logic [IDX_W-1:0]          row;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      size_error;
   } matrix_elem_type;

   class matrix_tracker;
      logic [1:0]                mode;
      int unsigned               a_cols, a_rows, b_cols, b_rows;
      logic signed [VALUE_W-1:0] scalar;
      logic signed [VALUE_W-1:0] a_store [DEPTH];
      logic signed [VALUE_W-1:0] b_store [DEPTH];
      matrix_elem_type           expected_elems [$];

      int unsigned errors, elems_checked, loads, runs, size_errors;
      bit [3:0]    modes_run;

      function new();
         mode    = MODE_ADD;
         a_cols  = 1;
         a_rows  = 1;
         b_cols  = 1;
         b_rows  = 1;
         scalar  = SCALAR_RESET;
         a_store = '{default: '0};
         b_store = '{default: '0};
      endfunction

      function int pending();
         return expected_elems.size();
      endfunction

      // queue one expected element behind those already waiting
      function void add_expected(matrix_elem_type e);
         expected_elems.insert(expected_elems.size(), e);
      endfunction

      function logic signed [VALUE_W-1:0] clamp(longint v);
         if (v > SAT_HI) return VALUE_W'(SAT_HI);
         if (v < SAT_LO) return VALUE_W'(SAT_LO);
         return VALUE_W'(v);
      endfunction

      // zero is dropped, anything above the largest size is pulled down to it
      function bit resize(inout int unsigned dim, input logic [CSR_DATA_W-1:0] data);
         logic [CSR_DIM_W-1:0] v;
         v = data[CSR_DIM_W-1:0];
         if (v == 0) return 1'b0;
         dim = (v > MAX_DIM) ? MAX_DIM : v;
         return 1'b1;
      endfunction

      function void note_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_MODE:   mode = data[1:0];
            CSR_A_COLS: if (resize(a_cols, data)) a_store = '{default: '0};
            CSR_A_ROWS: if (resize(a_rows, data)) a_store = '{default: '0};
            CSR_B_COLS: if (resize(b_cols, data)) b_store = '{default: '0};
            CSR_B_ROWS: if (resize(b_rows, data)) b_store = '{default: '0};
            CSR_SCALAR: scalar = data;
            default: ;
         endcase
      endfunction

      function void predict_run();
         int unsigned     rows, cols;
         longint          acc, av;
         matrix_elem_type e;
         runs++;
         modes_run[mode] = 1'b1;
         if (((mode == MODE_ADD || mode == MODE_SUB) && (a_cols != b_cols || a_rows != b_rows))
             || (mode == MODE_MUL && a_cols != b_rows)) begin
            e = '{col: '0, row: '0, value: '0, last: 1'b1, size_error: 1'b1};
            add_expected(e);
            size_errors++;
            return;
         end
         rows = a_rows;
         cols = (mode == MODE_MUL) ? b_cols : a_cols;
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               av = a_store[r * MAX_DIM + c];
               case (mode)
                  MODE_ADD: acc = av + longint'(b_store[r * MAX_DIM + c]);
                  MODE_SUB: acc = av - longint'(b_store[r * MAX_DIM + c]);
                  MODE_MUL: begin
                     acc = 0;
                     for (int i = 0; i < a_cols; i++)
                        acc += (longint'(a_store[r * MAX_DIM + i]) *
                                longint'(b_store[i * MAX_DIM + c])) >>> FRAC_BITS;
                  end
                  default: acc = (av * longint'(scalar)) >>> FRAC_BITS;
               endcase
               e.col        = IDX_W'(c);
               e.row        = IDX_W'(r);
               e.value      = clamp(acc);
               e.last       = (r + 1 == rows) && (c + 1 == cols);
               e.size_error = 1'b0;
               add_expected(e);
            end
         end
      endfunction

      // returns 1 when the transaction changed something or caused results
      function bit note_item(logic [1:0] op, logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                             logic signed [VALUE_W-1:0] value);
         case (op)
            OP_LOAD_A: begin
               if (col >= a_cols || row >= a_rows) return 1'b0;
               a_store[addr_idx(row, col)] = clamp(value);
               loads++;
            end
            OP_LOAD_B: begin
               if (col >= b_cols || row >= b_rows) return 1'b0;
               b_store[addr_idx(row, col)] = clamp(value);
               loads++;
            end
            OP_RUN: predict_run();
            default: return 1'b0;
         endcase
         return 1'b1;
      endfunction

      function int unsigned addr_idx(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
         return row * MAX_DIM + col;
      endfunction

      function void compare(string field, logic signed [63:0] want, logic signed [63:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_elem(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                               logic signed [VALUE_W-1:0] value, logic last, logic size_error);
         matrix_elem_type e;
         if (expected_elems.size() == 0) begin
            $error("result at row %0d col %0d with nothing expected", row, col);
            errors++;
            return;
         end
         e = expected_elems.pop_front();
         elems_checked++;
         compare("out_col", e.col, col);
         compare("out_row", e.row, row);
         compare("out_value", e.value, value);
         compare("last", e.last, last);
         compare("size_error", e.size_error, size_error);
      endfunction
   endclass

endpackage

>>> tb/tb_small_matrix_arithmetic_core.sv
`timescale 1ns / 1ps
// testbench top level: drives loads, runs and register writes and checks every result
module tb_small_matrix_arithmetic_core;

   import sma_pkg::*;
   import matrix_tracker_pkg::*;

   localparam int     ITEM_TARGET   = 430;
   localparam int     QUIET_TAIL    = 70;     // last transactions go in without gaps
   localparam int     SETTLE_CYCLES = 8;      // extra wait after the last expected result
   localparam longint CYCLE_LIMIT   = 2_000_000;

   localparam logic [1:0]           OP_UNUSED   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_0 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_1 = 3'd7;
   localparam logic [VALUE_W-1:0]   VAL_MAX     = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0]   VAL_MIN     = 32'h8000_0000;
   localparam logic [VALUE_W-1:0]   VAL_ONE     = 32'h0001_0000;   // 1.0 in q16.16

   logic clock = 1'b0;
   logic reset;

   logic                        start;
   logic                        busy;
   logic [1:0]                  req_op;
   logic [IDX_W-1:0]            req_col;
   logic [IDX_W-1:0]            req_row;
   logic signed [VALUE_W-1:0]   req_value;
   logic                        rsp_strobe;
   logic [IDX_W-1:0]            rsp_out_col;
   logic [IDX_W-1:0]            rsp_out_row;
   logic signed [VALUE_W-1:0]   rsp_out_value;
   logic                        rsp_last;
   logic                        rsp_size_error;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [CSR_DATA_W-1:0]       csr_data;

   matrix_tracker tracker;
   int            items_sent;
   int            reg_writes;
   int            phases;
   longint        cycle_count;
   bit            quiet;    // no idling at all in the final stretch
   bit            calm;     // this phase runs without idling

   small_matrix_arithmetic_core u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_value      (req_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_value  (rsp_out_value),
      .rsp_last       (rsp_last),
      .rsp_size_error (rsp_size_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // results cannot be held off, so every strobe is a transaction at this edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_elem(rsp_out_col, rsp_out_row, rsp_out_value, rsp_last, rsp_size_error);
   end

   // watchdog: a hang anywhere ends the run as a failure
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("no progress after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly small fixed-point numbers, with the range ends and full random words mixed in
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3, 4: return $urandom;
         default: return VALUE_W'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      endcase
   endfunction

   // small sizes keep runs short; zero and oversize writes show up now and then
   function automatic logic [CSR_DIM_W-1:0] pick_dim();
      case ($urandom_range(0, 23))
         0: return '0;
         1: return CSR_DIM_W'($urandom_range(MAX_DIM + 1, 15));
         2: return CSR_DIM_W'(MAX_DIM);
         default: return CSR_DIM_W'($urandom_range(1, 3));
      endcase
   endfunction

   // request side goes idle with random contents on the fields
   task automatic drop_start();
      @(negedge clock);
      start     = 1'b0;
      req_op    = 2'($urandom);
      req_col   = IDX_W'($urandom);
      req_row   = IDX_W'($urandom);
      req_value = $urandom;
   endtask

   task automatic maybe_idle();
      int gap;
      quiet = (items_sent >= ITEM_TARGET - QUIET_TAIL);
      if (quiet || calm || $urandom_range(0, 3) != 0) return;
      gap = $urandom_range(1, 17);
      drop_start();
      repeat (gap - 1) @(negedge clock);
   endtask

   // start stays high from one transaction to the next when no gap falls between them
   task automatic send_item(input logic [1:0] op, input int col, input int row,
                            input logic [VALUE_W-1:0] value);
      maybe_idle();
      @(negedge clock);
      start     = 1'b1;
      req_op    = op;
      req_col   = IDX_W'(col);
      req_row   = IDX_W'(row);
      req_value = value;
      do @(posedge clock); while (busy);
      if (tracker.note_item(req_op, req_col, req_row, req_value))
         items_sent++;
   endtask

   // hold off until every expected result is back and the engine has gone quiet
   task automatic settle();
      drop_start();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      tracker.note_reg(index, data);
      reg_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // stray loads anywhere in the index space, or the unused opcode
   task automatic noise();
      if ($urandom_range(0, 2) == 0)
         send_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      else
         send_item(2'($urandom_range(0, 1)), $urandom_range(0, 7), $urandom_range(0, 7),
                   pick_value());
   endtask

   // walk the configured size of one store, leaving the odd element as it was
   task automatic fill_store(input logic [1:0] op);
      int cols, rows;
      cols = (op == OP_LOAD_A) ? tracker.a_cols : tracker.b_cols;
      rows = (op == OP_LOAD_A) ? tracker.a_rows : tracker.b_rows;
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if ($urandom_range(0, 15) == 0) noise();
            if ($urandom_range(0, 7) != 0) send_item(op, c, r, pick_value());
         end
      end
   endtask

   task automatic directed_part();
      // reset state: 1x1 add of two cleared stores
      send_item(OP_RUN, 0, 0, '0);
      send_item(OP_LOAD_A, 0, 0, VAL_MAX);
      send_item(OP_LOAD_B, 0, 0, VAL_MAX);
      send_item(OP_RUN, 0, 0, '0);
      // load outside the size and the unused opcode, both without effect
      send_item(OP_LOAD_A, 7, 7, VAL_ONE);
      send_item(OP_UNUSED, 7, 7, VAL_MAX);

      // subtract, saturating at both ends
      settle();
      write_reg(CSR_MODE, 32'(MODE_SUB));
      send_item(OP_LOAD_B, 0, 0, VAL_MIN);
      send_item(OP_RUN, 0, 0, '0);
      send_item(OP_LOAD_A, 0, 0, VAL_MIN);
      send_item(OP_LOAD_B, 0, 0, 32'd1);
      send_item(OP_RUN, 0, 0, '0);

      // scalar of most negative value squares to far beyond range
      settle();
      write_reg(CSR_MODE, 32'(MODE_SCALE));
      write_reg(CSR_SCALAR, VAL_MIN);
      send_item(OP_RUN, 0, 0, '0);
      // a negative product below one lsb truncates towards minus infinity
      settle();
      write_reg(CSR_SCALAR, 32'hFFFF_FFFF);
      send_item(OP_LOAD_A, 0, 0, 32'd1);
      send_item(OP_RUN, 0, 0, '0);

      // product with inner sizes apart gives the size error; a zero size write is dropped
      settle();
      write_reg(CSR_MODE, 32'(MODE_MUL));
      write_reg(CSR_A_ROWS, '0);
      write_reg(CSR_A_COLS, 32'd2);
      send_item(OP_RUN, 0, 0, '0);

      // 1x2 times 2x1 with everything at the top of the range
      settle();
      write_reg(CSR_B_ROWS, 32'd2);
      send_item(OP_LOAD_A, 0, 0, VAL_MAX);
      send_item(OP_LOAD_A, 1, 0, VAL_MAX);
      send_item(OP_LOAD_B, 0, 0, VAL_MAX);
      send_item(OP_LOAD_B, 0, 1, VAL_MAX);
      send_item(OP_RUN, 0, 0, '0);
      // sizes that suit the product do not suit an elementwise add
      settle();
      write_reg(CSR_MODE, 32'(MODE_ADD));
      send_item(OP_RUN, 0, 0, '0);

      // unused indexes, then oversize writes that land on the largest size
      settle();
      write_reg(CSR_SPARE_0, $urandom);
      write_reg(CSR_SPARE_1, $urandom);
      write_reg(CSR_A_COLS, 32'd15);
      write_reg(CSR_A_ROWS, 32'd15);
      write_reg(CSR_B_COLS, 32'd15);
      write_reg(CSR_B_ROWS, 32'd15);
      write_reg(CSR_MODE, 32'(MODE_MUL));
      send_item(OP_LOAD_A, 7, 7, 32'h0004_0000);
      send_item(OP_LOAD_B, 7, 7, 32'h0002_0000);
      send_item(OP_RUN, 7, 7, '0);
   endtask

   // one phase: new settings while idle, loads across the configured sizes mixed with stray items, then a few runs
   task automatic random_phase();
      logic [1:0]           sel_mode;
      logic [CSR_DIM_W-1:0] ac, ar, bc, br;
      int                   run_count;
      settle();
      phases++;
      calm     = ($urandom_range(0, 3) == 0);
      sel_mode = 2'($urandom);
      write_reg(CSR_MODE, {30'($urandom), sel_mode});
      if ($urandom_range(0, 4) != 0) begin
         ac = pick_dim();
         ar = pick_dim();
         if ($urandom_range(0, 7) == 0) begin
            bc = pick_dim();
            br = pick_dim();
         end else if (sel_mode == MODE_MUL) begin
            bc = pick_dim();
            br = ac;
         end else begin
            bc = ac;
            br = ar;
         end
         write_reg(CSR_A_COLS, {28'($urandom), ac});
         write_reg(CSR_A_ROWS, {28'($urandom), ar});
         write_reg(CSR_B_COLS, {28'($urandom), bc});
         write_reg(CSR_B_ROWS, {28'($urandom), br});
      end
      if ($urandom_range(0, 1) != 0)
         write_reg(CSR_SCALAR, pick_value());
      fill_store(OP_LOAD_A);
      fill_store(OP_LOAD_B);
      run_count = $urandom_range(1, 3);
      for (int k = 0; k < run_count; k++) begin
         // between runs touch up a few elements of either store
         if (k != 0) begin
            repeat ($urandom_range(1, 4))
               send_item(2'($urandom_range(0, 1)),
                         $urandom_range(0, tracker.a_cols - 1),
                         $urandom_range(0, tracker.a_rows - 1), pick_value());
         end
         send_item(OP_RUN, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
      end
   endtask

   initial begin
      tracker    = new();
      items_sent = 0;
      reg_writes = 0;
      phases     = 0;
      quiet      = 1'b0;
      calm       = 1'b0;
      reset      = 1'b1;
      start      = 1'b0;
      req_op     = OP_LOAD_A;
      req_col    = '0;
      req_row    = '0;
      req_value  = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_MODE;
      csr_data   = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_part();
      while (items_sent < ITEM_TARGET)
         random_phase();

      // let the last run drain, then a short quiet tail
      settle();

      $display("covered %0d effective transactions: %0d loads, %0d runs (%0d size errors)",
               items_sent, tracker.loads, tracker.runs, tracker.size_errors);
      $display("checked %0d result elements over %0d random phases, %0d register writes, modes %b",
               tracker.elems_checked, phases, reg_writes, tracker.modes_run);
      if (tracker.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
